// ===== rtl/text_line_folder_top_macros.svh =====
// Assertion helpers for the line folder.
`ifndef TEXT_LINE_FOLDER_TOP_MACROS_SVH
`define TEXT_LINE_FOLDER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLF_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlf_pkg.sv =====
`timescale 1ns / 1ps

package tlf_pkg;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;

    // Widest fold width; held store depth
    localparam logic [5:0] MAX_WIDTH  = 6'd63;
    localparam int         HOLD_DEPTH = 64;
    localparam int         HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam logic [5:0] WIDTH_RST  = 6'd63;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_word;

    // Write port of the held text store
    typedef struct packed {
        logic               en;
        logic [HOLD_AW-1:0] addr;
        logic [7:0]         data;
    } t_mem_wr;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/tlf_held_mem.sv =====
`timescale 1ns / 1ps

// Held text store: one write port, one read port with registered data.
module tlf_held_mem import tlf_pkg::*; (
    input  logic               i_clk,
    input  t_mem_wr            i_wr,
    input  logic [HOLD_AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [HOLD_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/text_line_folder_top.sv =====
`timescale 1ns / 1ps
// After an item is accepted the block enters its run state; the first result word is
// loaded into the output register once it is free. Held bytes are replayed from the store
// at one per cycle while the output is not stalled, then up to two tail bytes; no new item
// is taken until the last word is loaded. An item with no results (byte added to the held
// word) stays idle. Reset: synchronous, active low; clears held count, blank flag, column,
// output valid and width (63). Held store is not cleared and needs no clearing pass.
`include "text_line_folder_top_macros.svh"

module text_line_folder_top import tlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    // width register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    t_state     r_state, n_state;
    logic [5:0] r_width;
    logic [6:0] r_held_cnt, n_held_cnt;
    logic [6:0] r_column, n_column;
    logic       r_blank_held, n_blank_held;

    // replay plan of the current item
    logic [6:0] r_cnt, n_cnt;
    logic       r_subst, n_subst;
    logic [1:0] r_ntail, n_ntail;
    logic [7:0] r_tail0, n_tail0;
    logic [7:0] r_tail1, n_tail1;
    logic [6:0] r_pos, n_pos;
    t_mem_wr    r_dwr, n_dwr;

    t_out_word  r_out;
    logic       r_out_valid;

    t_mem_wr            wr;
    logic [HOLD_AW-1:0] rd_addr;
    logic [7:0]         rd_data;

    logic       in_acc;
    logic       load;
    logic       is_last;
    logic [6:0] total;
    logic [6:0] pos_inc;
    logic [6:0] eff_w;
    logic [6:0] col1;
    logic       fold;
    logic [7:0] cur_byte;
    logic       more_due;
    logic       pos_ok;

    tlf_held_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // effective width and fold test
    always_comb begin
        if (r_width == 6'd0) begin
            eff_w = 7'd1;
        end else if (r_width > MAX_WIDTH) begin
            eff_w = {1'b0, MAX_WIDTH};
        end else begin
            eff_w = {1'b0, r_width};
        end
    end

    assign col1    = (r_column == 7'd127) ? r_column : r_column + 7'd1;
    assign fold    = (col1 >= eff_w);
    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign load    = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign total   = r_cnt + {5'd0, r_ntail};
    assign pos_inc = r_pos + 7'd1;
    assign is_last = (pos_inc == total);

    // byte at the current replay position
    always_comb begin
        if (r_pos < r_cnt) begin
            cur_byte = (r_subst && (r_pos == 7'd0)) ? CH_NL : rd_data;
        end else if (r_pos == r_cnt) begin
            cur_byte = r_tail0;
        end else begin
            cur_byte = r_tail1;
        end
    end

    // planning and replay sequencer
    always_comb begin
        logic    is_blank;
        logic    full;
        t_mem_wr pw;

        n_state      = r_state;
        n_held_cnt   = r_held_cnt;
        n_column     = r_column;
        n_blank_held = r_blank_held;
        n_cnt        = r_cnt;
        n_subst      = r_subst;
        n_ntail      = r_ntail;
        n_tail0      = r_tail0;
        n_tail1      = r_tail1;
        n_pos        = r_pos;
        n_dwr        = r_dwr;
        wr           = '0;
        rd_addr      = '0;
        pw           = '0;
        is_blank     = (i_in_word.text_byte == CH_SPACE) || (i_in_word.text_byte == CH_TAB);
        full         = r_held_cnt[6];

        case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (in_acc) begin
                    n_pos   = 7'd0;
                    n_cnt   = 7'd0;
                    n_subst = 1'b0;
                    n_ntail = 2'd0;
                    n_tail0 = i_in_word.text_byte;
                    n_tail1 = CH_NL;
                    if (i_in_word.end_of_text) begin
                        // flush held text
                        n_cnt        = r_held_cnt;
                        n_held_cnt   = 7'd0;
                        n_blank_held = 1'b0;
                    end else if (i_in_word.text_byte == CH_NL) begin
                        n_cnt        = r_held_cnt;
                        n_ntail      = 2'd1;
                        n_tail0      = CH_NL;
                        n_held_cnt   = 7'd0;
                        n_blank_held = 1'b0;
                        n_column     = 7'd0;
                    end else if (is_blank) begin
                        n_cnt = r_held_cnt;
                        if (fold) begin
                            // new blank turns into the newline at once
                            n_ntail      = 2'd1;
                            n_tail0      = CH_NL;
                            n_held_cnt   = 7'd0;
                            n_blank_held = 1'b0;
                            n_column     = 7'd0;
                        end else begin
                            pw.en        = 1'b1;
                            pw.addr      = '0;
                            pw.data      = i_in_word.text_byte;
                            n_held_cnt   = 7'd1;
                            n_blank_held = 1'b1;
                            n_column     = col1;
                        end
                    end else if (r_blank_held) begin
                        if (fold) begin
                            // held blank becomes newline, word follows
                            n_cnt        = r_held_cnt;
                            n_subst      = 1'b1;
                            n_ntail      = full ? 2'd0 : 2'd1;
                            n_column     = full ? r_held_cnt - 7'd1 : r_held_cnt;
                            n_held_cnt   = 7'd0;
                            n_blank_held = 1'b0;
                        end else begin
                            pw.en    = !full;
                            pw.addr  = r_held_cnt[HOLD_AW-1:0];
                            pw.data  = i_in_word.text_byte;
                            n_held_cnt = full ? r_held_cnt : r_held_cnt + 7'd1;
                            n_column = col1;
                        end
                    end else begin
                        // pass through, forced fold after it if the width is reached
                        n_ntail  = fold ? 2'd2 : 2'd1;
                        n_column = fold ? 7'd0 : col1;
                    end

                    if ((n_cnt == 7'd0) && (n_ntail == 2'd0)) begin
                        wr = pw;
                    end else begin
                        n_dwr   = pw;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rd_addr = load ? pos_inc[HOLD_AW-1:0] : r_pos[HOLD_AW-1:0];
                if (load) begin
                    n_pos = pos_inc;
                    if (is_last) begin
                        // replay done, commit the deferred store write
                        wr       = r_dwr;
                        n_dwr.en = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= WIDTH_RST;
            r_held_cnt   <= 7'd0;
            r_column     <= 7'd0;
            r_blank_held <= 1'b0;
            r_dwr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_cnt   <= n_held_cnt;
            r_column     <= n_column;
            r_blank_held <= n_blank_held;
            r_dwr        <= n_dwr;
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // plan and output payload
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_subst    <= n_subst;
        r_ntail    <= n_ntail;
        r_tail0    <= n_tail0;
        r_tail1    <= n_tail1;
        r_pos      <= n_pos;
        if (load) begin
            r_out.out_byte <= cur_byte;
            r_out.last     <= is_last;
        end
    end

    // checks
    assign more_due = o_out_valid && i_out_ready && !o_out_word.last;
    assign pos_ok   = (r_state != ST_RUN) || (r_pos < total);

    `TLF_ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, r_held_cnt < 7'd64, "held text overflow")
    `TLF_ASSERT_ALWAYS(a_blank_cnt, i_clk, i_rst_n, r_blank_held == (|r_held_cnt), "blank flag off")
    `TLF_ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, pos_ok, "replay position past end")
    `TLF_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, more_due, o_out_valid, "gap inside result burst")

endmodule

// ===== sim/text_fold_checker.sv =====
`timescale 1ns / 1ps

module text_fold_checker import tlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [5:0] i_cfg_data,
    output int         o_words_due,
    output int         o_fail_count
);

    localparam int MAX_RESULTS = 64;

    // Mirror of the folder state
    logic [7:0] held_bytes [HOLD_DEPTH];
    logic [6:0] held_len;
    logic [6:0] column;
    logic       blank_held;
    logic [5:0] fold_width;

    // Folded words still owed by the block, oldest first
    t_out_word  folded_due [$];
    // Bytes produced by the item being folded
    logic [7:0] item_bytes [$];
    t_out_word  want;

    // Replay the held text, then nothing is held
    task automatic send_held_text();
        int k;
        for (k = 0; k < int'(held_len); k++)
            item_bytes.push_back(held_bytes[k]);
        held_len   = '0;
        blank_held = 1'b0;
    endtask

    // Store is never full while the width is at most 63
    task automatic hold_byte(input logic [7:0] b);
        if (held_len < HOLD_DEPTH) begin
            held_bytes[held_len[5:0]] = b;
            held_len = held_len + 7'd1;
        end
    endtask

    // Work out the folded words one input word causes
    task automatic fold_item(input t_in_word w);
        logic [6:0] eff_width;
        logic [6:0] word_len;
        logic       is_blank;
        t_out_word  ow;
        int         k;
        item_bytes.delete();
        // a width of 0 folds like a width of 1
        eff_width = (fold_width == '0) ? 7'd1 : {1'b0, fold_width};
        is_blank  = (w.text_byte == CH_SPACE) || (w.text_byte == CH_TAB);
        if (w.end_of_text) begin
            send_held_text();
        end else if (w.text_byte == CH_NL) begin
            send_held_text();
            item_bytes.push_back(CH_NL);
            column = '0;
        end else begin
            if (is_blank) begin
                send_held_text();
                hold_byte(w.text_byte);
                blank_held = 1'b1;
            end else if (blank_held) begin
                hold_byte(w.text_byte);
            end else begin
                item_bytes.push_back(w.text_byte);
            end
            if (column < 7'd127)
                column = column + 7'd1;
            if (column >= eff_width) begin
                if (blank_held && held_len != '0) begin
                    // held blank turns into the line break, word goes on the new line
                    word_len      = held_len - 7'd1;
                    held_bytes[0] = CH_NL;
                    send_held_text();
                    column = word_len;
                end else begin
                    // no blank to break at: force a break after this byte
                    item_bytes.push_back(CH_NL);
                    column = '0;
                end
            end
        end
        for (k = 0; k < item_bytes.size() && k < MAX_RESULTS; k++) begin
            ow.out_byte = item_bytes[k];
            ow.last     = (k == item_bytes.size() - 1) || (k == MAX_RESULTS - 1);
            folded_due.push_back(ow);
        end
    endtask

    // Track config and input words, compare output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_len     = '0;
            column       = '0;
            blank_held   = 1'b0;
            fold_width   = WIDTH_RST;
            o_fail_count = 0;
            folded_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                fold_width = i_cfg_data;
            if (i_in_valid && i_in_ready)
                fold_item(i_in_word);
            if (i_out_valid && i_out_ready) begin
                if (folded_due.size() == 0) begin
                    $display("%0t: unexpected word: byte %h last %b",
                             $time, i_out_word.out_byte, i_out_word.last);
                    o_fail_count++;
                end else begin
                    want = folded_due.pop_front();
                    if (i_out_word.out_byte !== want.out_byte ||
                        i_out_word.last !== want.last) begin
                        $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                                 $time, want.out_byte, want.last,
                                 i_out_word.out_byte, i_out_word.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_words_due = folded_due.size();
    end

endmodule

// ===== sim/tb_text_line_folder_top.sv =====
`timescale 1ns / 1ps

module tb_text_line_folder_top;
    import tlf_pkg::*;

    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    int words_due;
    int fail_count;
    int tx_idle_pct = 20;
    int rx_idle_pct = 74;
    int hold_requests = 0;

    text_line_folder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    text_fold_checker fold_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_words_due  (words_due),
        .o_fail_count (fail_count)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Output side: random stalls, plus one long hold on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ready    = 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one input word after a random gap and wait until it is taken
    task automatic offer_word(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_word.text_byte     <= b;
        in_word.end_of_text   <= eot;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (words_due != 0);
    endtask

    // Width is only written with the block idle
    task automatic write_width(input logic [5:0] w);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly words of letters between blanks, some breaks, end markers and raw bytes
    task automatic offer_random(input int letter_pct);
        logic [7:0] ch;
        int         pick;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(25));
        if (pick < letter_pct) begin
            offer_word(ch + "a", 1'b0);
        end else begin
            pick = $urandom_range(99);
            if (pick < 45)
                offer_word(CH_SPACE, 1'b0);
            else if (pick < 60)
                offer_word(CH_TAB, 1'b0);
            else if (pick < 70)
                offer_word(CH_NL, 1'b0);
            else if (pick < 80)
                offer_word(8'($urandom_range(255)), 1'b1);
            else
                offer_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic run_phase(input logic [5:0] w, input int letter_pct, input logic long_hold);
        int n;
        write_width(w);
        if (long_hold)
            hold_requests <= hold_requests + 1;
        for (n = 0; n < PHASE_ITEMS; n++)
            offer_random(letter_pct);
    endtask

    // Stimulus and verdict
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fold at a held tab, then a plain byte after the break
        write_width(6'd8);
        offer_word("a", 1'b0);
        offer_word("b", 1'b0);
        offer_word(CH_SPACE, 1'b0);
        offer_word("c", 1'b0);
        offer_word("d", 1'b0);
        offer_word(CH_TAB, 1'b0);
        offer_word("e", 1'b0);
        offer_word("f", 1'b0);
        offer_word("g", 1'b0);
        // end marker with nothing held, then with a held word
        offer_word(8'hFF, 1'b1);
        offer_word(CH_SPACE, 1'b0);
        offer_word("h", 1'b0);
        offer_word(8'h00, 1'b1);
        // byte extremes, newline, newline flushing a lone blank
        offer_word(8'h00, 1'b0);
        offer_word(8'hFF, 1'b0);
        offer_word(CH_NL, 1'b0);
        offer_word(CH_SPACE, 1'b0);
        offer_word(CH_NL, 1'b0);
        // forced break with no blank held
        write_width(6'd3);
        offer_word("p", 1'b0);
        offer_word("q", 1'b0);
        offer_word("r", 1'b0);
        // width lowered mid-line: break on the next byte
        write_width(6'd20);
        offer_word("s", 1'b0);
        offer_word("t", 1'b0);
        write_width(6'd1);
        offer_word("u", 1'b0);
        // zero width acts as one, blank alone on a line
        write_width(6'd0);
        offer_word("v", 1'b0);
        offer_word(CH_SPACE, 1'b0);

        // sender idles a little, receiver a lot
        run_phase(6'd63, 70, 1'b0);
        run_phase(6'd12, 85, 1'b0);
        // the other way round
        tx_idle_pct = 74;
        rx_idle_pct <= 20;
        run_phase(6'd1, 60, 1'b0);
        run_phase(6'($urandom_range(62, 2)), 70, 1'b0);
        // no idling; long receiver hold backs up the input
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_phase(6'd0, 60, 1'b1);
        run_phase(6'd5, 90, 1'b0);

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
